>>> design/lru_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// lru_page_replacement_defines.svh
// Assertion macros used by the LRU page replacement checker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Sizes, sequencer states and helpers for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

  localparam int FRAMES  = 16;
  localparam int PAGES   = 64;

  localparam int FRAME_W = $clog2(FRAMES);      // frame index width
  localparam int CNT_W   = $clog2(FRAMES + 1);  // frame count width
  localparam int SLOT_W  = $clog2(PAGES);       // timestamp store address
  localparam int PAGE_W  = 6;                   // page_number field
  localparam int NF_W    = 5;                   // num_frames register
  localparam int TIME_W  = 32;

  localparam logic [NF_W-1:0]   NF_RESET = NF_W'(16);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Frame count actually used: zero acts as one, large values clamp
  function automatic logic [CNT_W-1:0] active_frames(input logic [NF_W-1:0] nf);
    logic [CNT_W-1:0] n;
    if (nf == '0) begin
      n = CNT_W'(1);
    end else if (32'(nf) > FRAMES) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(nf);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement with last-use timestamps
// References are taken one at a time: a new one is accepted only once the
// last has left the update state. Frames are scanned one per cycle over the
// n active frames (at most 16), through the shared timestamp compare.
// Reset: frames empty, counters zero, num_frames 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement
  import lru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [NF_W-1:0]   cfg_wdata,
  // page reference transaction
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [PAGE_W-1:0] page_number,
  // result transaction
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              hit,
  output      logic [FRAME_W-1:0] frame_index,
  output      logic              evicted_valid,
  output      logic [PAGE_W-1:0] evicted_page,
  output      logic [TIME_W-1:0] fault_count,
  output      logic              time_saturated
);

  // Control state
  state_t               state;
  state_t               state_next;
  logic [NF_W-1:0]      num_frames;
  logic [FRAMES-1:0]    frame_valid;
  logic [TIME_W-1:0]    ref_time;
  logic [TIME_W-1:0]    fault_total;

  // Frame contents and per-page stamp memory
  logic [PAGE_W-1:0]    frame_page [FRAMES];
  logic [TIME_W-1:0]    stamp_mem  [PAGES];
  logic [TIME_W-1:0]    mem_q;

  // Per-transaction working registers
  logic [PAGE_W-1:0]    page;
  logic [CNT_W-1:0]     k;
  logic                 hit_found;
  logic [FRAME_W-1:0]   hit_frame;
  logic                 empty_found;
  logic [FRAME_W-1:0]   empty_frame;
  logic                 rd_pend;
  logic [FRAME_W-1:0]   rd_idx;
  logic [PAGE_W-1:0]    rd_page;
  logic [TIME_W-1:0]    best_time;
  logic [FRAME_W-1:0]   best_frame;
  logic [PAGE_W-1:0]    best_page;

  // Combinational helpers
  logic [CNT_W-1:0]     n_act;
  logic [FRAME_W-1:0]   kidx;
  logic                 k_live;
  logic                 cur_valid;
  logic [PAGE_W-1:0]    cur_page;
  logic                 cur_match;
  logic                 scan_en;
  logic                 upd_en;
  logic                 out_free;
  logic [FRAME_W-1:0]   sel_frame;
  logic [TIME_W-1:0]    ref_time_inc;
  logic [TIME_W-1:0]    fault_inc;

  assign n_act     = active_frames(num_frames);
  assign kidx      = k[FRAME_W-1:0];
  assign k_live    = (k < n_act);
  assign cur_valid = frame_valid[kidx];
  assign cur_page  = frame_page[kidx];
  assign cur_match = cur_valid && (cur_page == page);
  assign out_free  = !out_valid || out_ready;

  assign sel_frame    = hit_found ? hit_frame : (empty_found ? empty_frame : best_frame);
  assign ref_time_inc = (ref_time == TIME_MAX) ? ref_time : ref_time + TIME_W'(1);
  assign fault_inc    = (fault_total == TIME_MAX) ? fault_total
                                                  : fault_total + TIME_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!k_live || cur_match) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    upd_en   = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   scan_en  = k_live;
      ST_UPDATE: upd_en   = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_frames  <= NF_RESET;
      frame_valid <= '0;
      ref_time    <= '0;
      fault_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) num_frames <= cfg_wdata;
      if (upd_en) begin
        ref_time  <= ref_time_inc;
        out_valid <= 1'b1;
        if (!hit_found) begin
          frame_valid[sel_frame] <= 1'b1;
          fault_total            <= fault_inc;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stamp memory: one read port for the scan, one write port for the update
  always_ff @(posedge clk) begin
    if (scan_en) mem_q <= stamp_mem[cur_page[SLOT_W-1:0]];
    if (upd_en)  stamp_mem[page[SLOT_W-1:0]] <= ref_time;
  end

  // Scan: hit and empty search on frame k, stamp compare on frame k-1
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      page        <= page_number;
      k           <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      rd_pend     <= 1'b0;
    end else if (state == ST_SCAN) begin
      // shared compare unit: keep the oldest stamp, first index on ties
      if (rd_pend && ((rd_idx == '0) || (mem_q < best_time))) begin
        best_time  <= mem_q;
        best_frame <= rd_idx;
        best_page  <= rd_page;
      end
      rd_pend <= scan_en;
      if (scan_en) begin
        rd_idx  <= kidx;
        rd_page <= cur_page;
        k       <= k + CNT_W'(1);
        if (cur_match) begin
          hit_found <= 1'b1;
          hit_frame <= kidx;
        end else if (!cur_valid && !empty_found) begin
          empty_found <= 1'b1;
          empty_frame <= kidx;
        end
      end
    end
  end

  // Update: install page on a miss and load the result register
  always_ff @(posedge clk) begin
    if (upd_en) begin
      if (!hit_found) frame_page[sel_frame] <= page;
      hit            <= hit_found;
      frame_index    <= sel_frame;
      evicted_valid  <= !hit_found && !empty_found;
      evicted_page   <= (!hit_found && !empty_found) ? best_page : '0;
      fault_count    <= hit_found ? fault_total : fault_inc;
      time_saturated <= (ref_time_inc == TIME_MAX);
    end
  end

endmodule

`default_nettype wire

>>> design/lru_checker.sv
// ----------------------------------------------------------------------------
// lru_checker
// Port-level checks on the result channel of the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_defines.svh"

module lru_checker
  import lru_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               hit,
  input wire logic [FRAME_W-1:0] frame_index,
  input wire logic               evicted_valid,
  input wire logic [PAGE_W-1:0]  evicted_page,
  input wire logic [TIME_W-1:0]  fault_count,
  input wire logic               time_saturated
);

  // a hit never replaces a page
  `LRU_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted_valid, "eviction reported on a hit")

  // no eviction means a zero evicted page
  `LRU_ASSERT_NOW(a_evict_page_zero, out_valid && !evicted_valid, evicted_page == '0, "evicted page set without eviction")

  // once the reference counter saturates the flag stays up
  `LRU_ASSERT_NEXT(a_sat_sticky, out_valid && time_saturated, time_saturated, "time_saturated dropped")

  // a stalled result holds
  `LRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_index) && $stable(fault_count), "result changed while stalled")

endmodule

bind lru_page_replacement lru_checker u_lru_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the LRU page replacement block
// Streams page references through the block under random source gaps and
// sink stalls. A behavioral predictor tracks frames, per-page timestamps and
// the fault count, and every result transaction is checked against it.
// The frame count is reprogrammed between drained phases, extremes included.
// ----------------------------------------------------------------------------

module tb_top;
  import lru_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [TIME_W-1:0]  faults;
    logic               time_sat;
  } lru_result_t;

  // DUT signals, the driven inputs known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [NF_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PAGE_W-1:0] page_number = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [FRAME_W-1:0] frame_index;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic [TIME_W-1:0] fault_count;
  logic              time_saturated;

  // Predictor state
  logic [NF_W-1:0]   nf_model = NF_RESET;
  logic [PAGE_W-1:0] res_page [FRAMES];
  logic              res_valid [FRAMES];
  logic [TIME_W-1:0] last_use [PAGES];
  logic [TIME_W-1:0] fault_total = '0;
  logic [TIME_W-1:0] ref_clock = '0;

  logic [PAGE_W-1:0] pending_refs [$];
  lru_result_t       expected_results [$];
  int                mismatches = 0;
  logic              burst = 1'b0;
  int                src_gap = 0;
  int                sink_stall = 0;

  lru_page_replacement dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .time_saturated(time_saturated)
  );

  // Clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < FRAMES; k++) begin
      res_page[k]  = '0;
      res_valid[k] = 1'b0;
    end
    for (int k = 0; k < PAGES; k++) last_use[k] = '0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Look up one page reference and update the frame table
  function automatic lru_result_t resolve_reference(input logic [PAGE_W-1:0] page);
    lru_result_t       r;
    int                n;
    int                k;
    int                victim;
    logic              found;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] stamp;
    r = '0;
    // zero acts as one, anything past FRAMES clamps
    if (nf_model == '0) n = 1;
    else if (int'(nf_model) > FRAMES) n = FRAMES;
    else n = int'(nf_model);

    found = 1'b0;
    for (k = 0; k < n; k++) begin
      if (!found && res_valid[k] && res_page[k] == page) begin
        found = 1'b1;
        r.frame = FRAME_W'(k);
      end
    end
    r.hit = found;

    if (!found) begin
      // lowest empty frame first
      for (k = 0; k < n; k++) begin
        if (!found && !res_valid[k]) begin
          found = 1'b1;
          r.frame = FRAME_W'(k);
        end
      end
      // all full: oldest stamp, ties to the lowest index
      if (!found) begin
        victim = 0;
        oldest = last_use[int'(res_page[0]) % PAGES];
        for (k = 1; k < n; k++) begin
          stamp = last_use[int'(res_page[k]) % PAGES];
          if (stamp < oldest) begin
            oldest = stamp;
            victim = k;
          end
        end
        r.frame    = FRAME_W'(victim);
        r.ev_valid = 1'b1;
        r.ev_page  = res_page[victim];
      end
      res_page[r.frame]  = page;
      res_valid[r.frame] = 1'b1;
      if (fault_total != TIME_MAX) fault_total = fault_total + 1'b1;
    end

    last_use[int'(page) % PAGES] = ref_clock;
    if (ref_clock != TIME_MAX) ref_clock = ref_clock + 1'b1;
    r.faults   = fault_total;
    r.time_sat = (ref_clock == TIME_MAX);
    return r;
  endfunction

  // Driver: hands pending references to the block, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(resolve_reference(page_number));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          in_valid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (pending_refs.size() > 0) begin
          in_valid    <= 1'b1;
          page_number <= pending_refs.pop_front();
          src_gap     <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: random sink stalls, compare each result transaction
  always @(posedge clk) begin : monitor
    lru_result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", TIME_W'(want.hit), TIME_W'(hit));
          check_field("frame_index", TIME_W'(want.frame), TIME_W'(frame_index));
          check_field("evicted_valid", TIME_W'(want.ev_valid), TIME_W'(evicted_valid));
          check_field("evicted_page", TIME_W'(want.ev_page), TIME_W'(evicted_page));
          check_field("fault_count", want.faults, fault_count);
          check_field("time_saturated", TIME_W'(want.time_sat), TIME_W'(time_saturated));
        end
      end
      if (sink_stall > 0) begin
        out_ready  <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_stall <= pick_gap();
      end
    end
  end

  // Wait until nothing is queued, in flight or expected
  task automatic wait_drained();
    @(negedge clk);
    while (pending_refs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frames(input logic [NF_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    nf_model  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus: directed references, then random phases per frame count
  initial begin : stimulus
    logic [NF_W-1:0] plan [10];
    int              phase;
    int              n;
    int              ws;
    int              base;
    int              r;
    plan = '{5'd1, 5'd16, 5'd4, 5'd20, 5'd8, 5'd2, 5'd0, 5'd31, 5'd12, 5'd3};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset frame count: extremes, hits, fill to full, then one eviction
    pending_refs.push_back(6'd0);
    pending_refs.push_back(6'd63);
    pending_refs.push_back(6'd0);
    pending_refs.push_back(6'd63);
    for (int p = 1; p <= 14; p++) pending_refs.push_back(PAGE_W'(p));
    pending_refs.push_back(6'd42);
    wait_drained();

    // Zero frames act as one; upper frames keep their pages
    set_frames(5'd0);
    pending_refs.push_back(6'd5);
    pending_refs.push_back(6'd5);
    pending_refs.push_back(6'd7);
    wait_drained();

    // Above range clamps to all frames; a page may now sit twice
    set_frames(5'd31);
    pending_refs.push_back(6'd7);
    pending_refs.push_back(6'd3);
    pending_refs.push_back(6'd5);
    wait_drained();

    // Random phases, each starting from a drained block
    for (phase = 0; phase < 14; phase++) begin
      if (phase < 10) set_frames(plan[phase]);
      else set_frames(NF_W'($urandom_range(0, 31)));
      if (nf_model == '0) n = 1;
      else if (int'(nf_model) > FRAMES) n = FRAMES;
      else n = int'(nf_model);
      ws   = n + $urandom_range(0, 4);
      base = $urandom_range(0, PAGES - 1);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 58; i++) begin
        r = $urandom_range(0, 99);
        // working set gives hits, a cyclic sweep exercises eviction order
        if (r < 45) pending_refs.push_back(PAGE_W'((base + $urandom_range(0, ws - 1)) % PAGES));
        else if (r < 75) pending_refs.push_back(PAGE_W'((base + i % ws) % PAGES));
        else pending_refs.push_back(PAGE_W'($urandom_range(0, PAGES - 1)));
      end
      wait_drained();
    end
    burst = 1'b0;

    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/lru_pkg.sv
design/lru_page_replacement.sv
design/lru_checker.sv
verif/tb_top.sv
